FILE: src/gfc_pkg.sv
// Package for the graph forest checker: item types, cell control struct,
// FSM states and shared constants. Used by gfc_cell and the top level.
package gfc_pkg;

  localparam int GFC_MAX_VERTICES = 32;
  localparam int NODE_W = 5;
  localparam int ROW_OUT_W = 32;
  localparam int VC_W = 6;
  // Wide enough for any node number or vertex count in the supported range
  localparam int CMP_W = 7;
  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  // Operation codes carried in the mode field
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } gfc_in_t;

  typedef struct packed {
    logic                 forest;
    logic                 already_linked;
    logic [ROW_OUT_W-1:0] row_bits;
    logic                 error;
  } gfc_out_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic              add;    // valid edge add this cycle
    logic              merge;  // endpoints in different components
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } gfc_cell_ctl_t;

  typedef enum logic {
    GFC_IDLE,
    GFC_EXEC
  } gfc_state_t;

endpackage

FILE: src/gfc_cell.sv
// One vertex cell: holds its adjacency row and component label, passes the
// label/row read bus on to the next cell. Depends on gfc_pkg.
module gfc_cell import gfc_pkg::*; #(
  parameter int IDX = 0,
  parameter int VW  = GFC_MAX_VERTICES,
  parameter int LW  = $clog2(GFC_MAX_VERTICES)
) (
  input  logic          clk,
  input  logic          rst,
  input  gfc_cell_ctl_t ctl,
  input  logic [LW-1:0] la_new,
  input  logic [LW-1:0] lb_old,
  input  logic [LW-1:0] la_in,
  input  logic [LW-1:0] lb_in,
  input  logic [VW-1:0] row_in,
  output logic [LW-1:0] la_out,
  output logic [LW-1:0] lb_out,
  output logic [VW-1:0] row_out
);

  localparam logic [CMP_W-1:0] IdxC = CMP_W'(IDX);

  logic [VW-1:0] row;
  logic [LW-1:0] label;
  logic          hit_a;
  logic          hit_b;

  assign hit_a = (CMP_W'(ctl.node_a) == IdxC);
  assign hit_b = (CMP_W'(ctl.node_b) == IdxC);

  // Read bus: this cell ORs in its label and row when addressed
  assign la_out  = la_in  | (hit_a ? label : '0);
  assign lb_out  = lb_in  | (hit_b ? label : '0);
  assign row_out = row_in | (hit_a ? row : '0);

  // Edge add: set bits for the endpoints, relabel the absorbed component.
  // A self-loop hits both endpoints here and sets the same diagonal bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      row   <= '0;
      label <= LW'(IDX);
    end else if (ctl.add) begin
      if (hit_a) row[ctl.node_b] <= 1'b1;
      else if (hit_b) row[ctl.node_a] <= 1'b1;
      if (ctl.merge && label == lb_old) label <= la_new;
    end
  end

endmodule

FILE: src/graph_forest_checker_unit.sv
// Graph forest checker: adjacency matrix and component labels kept in a row
// of vertex cells, with an APB register for the vertex count.
// Depends on gfc_pkg and gfc_cell.

// An item is accepted in the idle state, in which the command is registered,
// and then executed: in the execute state the cell chain returns the
// labels of both endpoints and the row of node_a, and every cell relabels
// itself in parallel as the execute state ends. The execute state waits only
// while the output register still holds an untaken result; a new item can be
// accepted while a finished result waits. The execute path length is set by
// the read bus running through all MAX_VERTICES cells. A result carries the
// forest flag as it stands after the item; row_bits is the row of node_a
// after an edge add. Vertex numbers not below vertex_count (or MAX_VERTICES)
// give error with no change of state; a read checks node_a only.
module graph_forest_checker_unit import gfc_pkg::*; #(
  parameter int MAX_VERTICES = GFC_MAX_VERTICES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  gfc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gfc_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [CMP_W-1:0] MaxC = CMP_W'(MAX_VERTICES);

  gfc_state_t state, state_next;
  gfc_in_t       cmd;
  logic [VC_W-1:0] vertex_count;
  logic          forest_flag;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(vertex_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  // Handshake and FSM
  logic fire;
  assign in_stall = (state == GFC_EXEC);
  assign fire     = (state == GFC_EXEC) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) state <= GFC_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      GFC_IDLE: if (in_valid) state_next = GFC_EXEC;
      GFC_EXEC: if (fire) state_next = GFC_IDLE;
      default:  state_next = GFC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) cmd <= in_data;
  end

  // Validity of the vertex numbers
  logic a_ok, b_ok, is_add, err;
  assign a_ok   = (CMP_W'(cmd.node_a) < CMP_W'(vertex_count)) &&
                  (CMP_W'(cmd.node_a) < MaxC);
  assign b_ok   = (CMP_W'(cmd.node_b) < CMP_W'(vertex_count)) &&
                  (CMP_W'(cmd.node_b) < MaxC);
  assign is_add = (cmd.mode == MODE_ADD);
  assign err    = is_add ? !(a_ok && b_ok) : !a_ok;

  // Cell chain
  logic [LW-1:0]           la_bus [MAX_VERTICES+1];
  logic [LW-1:0]           lb_bus [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] row_bus [MAX_VERTICES+1];
  logic [LW-1:0]           la, lb;
  logic [MAX_VERTICES-1:0] row_a, row_sh, row_new;
  logic                    same, add_ok;
  gfc_cell_ctl_t           ctl;

  assign la_bus[0]  = '0;
  assign lb_bus[0]  = '0;
  assign row_bus[0] = '0;
  assign la    = la_bus[MAX_VERTICES];
  assign lb    = lb_bus[MAX_VERTICES];
  assign row_a = row_bus[MAX_VERTICES];

  assign same   = (la == lb);
  assign add_ok = is_add && !err;

  always_comb begin
    ctl.add    = fire && add_ok;
    ctl.merge  = fire && add_ok && !same;
    ctl.node_a = cmd.node_a;
    ctl.node_b = cmd.node_b;
  end

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    gfc_cell #(
      .IDX (i),
      .VW  (MAX_VERTICES),
      .LW  (LW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .la_new  (la),
      .lb_old  (lb),
      .la_in   (la_bus[i]),
      .lb_in   (lb_bus[i]),
      .row_in  (row_bus[i]),
      .la_out  (la_bus[i+1]),
      .lb_out  (lb_bus[i+1]),
      .row_out (row_bus[i+1])
    );
  end

  // Forest flag only ever drops
  always_ff @(posedge clk) begin
    if (rst) forest_flag <= 1'b1;
    else if (fire && add_ok && same) forest_flag <= 1'b0;
  end

  // Result register
  assign row_sh  = row_a >> cmd.node_b;
  assign row_new = row_a | (MAX_VERTICES'(1) << cmd.node_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.forest         <= forest_flag && !(add_ok && same);
      out_data.already_linked <= add_ok && row_sh[0];
      out_data.error          <= err;
      if (err)         out_data.row_bits <= '0;
      else if (is_add) out_data.row_bits <= ROW_OUT_W'(row_new);
      else             out_data.row_bits <= ROW_OUT_W'(row_a);
    end
  end

  // Checks
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    !forest_flag |=> !forest_flag)
    else $error("forest flag came back after a cycle was found");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == GFC_EXEC))
    else $error("accepted item did not enter execute");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("executed item produced no result");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |->
      (out_data.row_bits == '0 && !out_data.already_linked))
    else $error("error result carries row or link data");

endmodule

FILE: test/graph_forest_checker_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for graph_forest_checker_unit: a table of directed items, then random
// tree building and random bulk traffic, each result checked against an in-bench
// graph predictor. Depends on gfc_pkg and the RTL of the unit.
module graph_forest_checker_unit_tb;
  import gfc_pkg::*;

  localparam logic [2:0] VERTEX_COUNT_ADDR = 3'd0;
  localparam int         NV = GFC_MAX_VERTICES;

  // Results that can be read off without tracking the graph
  localparam gfc_out_t EMPTY_ROW     = {1'b1, 1'b0, 32'h0, 1'b0};
  localparam gfc_out_t BAD_VERTEX    = {1'b1, 1'b0, 32'h0, 1'b1};
  localparam gfc_out_t BAD_VERTEX_CY = {1'b0, 1'b0, 32'h0, 1'b1};

  typedef enum bit {
    ROW_ITEM,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        count;
    gfc_in_t   item;
    bit        known;
    gfc_out_t  want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gfc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gfc_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Graph predictor state
  logic [31:0]       adj_rows[NV];
  logic [NODE_W-1:0] comp_tag[NV];
  logic              still_forest;
  logic [VC_W-1:0]   vcount;

  gfc_out_t  awaited_results[$];
  plan_row_t plan[$];
  int        fail_count = 0;
  bit        no_gaps = 1'b0;
  int        stall_left = 0;

  graph_forest_checker_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  // Mostly short gaps, a few long ones; none during a quiet stretch
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int vertex_limit();
    return (vcount > NV) ? NV : int'(vcount);
  endfunction

  function automatic void clear_graph();
    int i;
    for (i = 0; i < NV; i++) begin
      adj_rows[i] = '0;
      comp_tag[i] = NODE_W'(i);
    end
    still_forest = 1'b1;
    vcount = VC_RESET;
  endfunction

  // Applies one item to the predicted graph and returns its result
  function automatic gfc_out_t apply_graph_item(gfc_in_t it);
    gfc_out_t          r;
    logic [NODE_W-1:0] tag_a;
    logic [NODE_W-1:0] tag_b;
    int                lim;
    int                i;
    r = '0;
    lim = vertex_limit();
    if (it.mode == MODE_ADD) begin
      if (it.node_a >= lim || it.node_b >= lim) begin
        r.error = 1'b1;
      end else begin
        tag_a = comp_tag[it.node_a];
        tag_b = comp_tag[it.node_b];
        r.already_linked = adj_rows[it.node_a][it.node_b];
        if (tag_a == tag_b) begin
          still_forest = 1'b0;
        end else begin
          for (i = 0; i < NV; i++)
            if (comp_tag[i] == tag_b) comp_tag[i] = tag_a;
        end
        adj_rows[it.node_a][it.node_b] = 1'b1;
        adj_rows[it.node_b][it.node_a] = 1'b1;
        r.row_bits = adj_rows[it.node_a];
      end
    end else if (it.node_a >= lim) begin
      r.error = 1'b1;
    end else begin
      r.row_bits = adj_rows[it.node_a];
    end
    r.forest = still_forest;
    return r;
  endfunction

  // Finds two valid vertices in different components, if any
  function automatic bit pick_split_pair(int lim, output logic [NODE_W-1:0] a,
                                         output logic [NODE_W-1:0] b);
    int t;
    int u;
    for (t = 0; t < 64; t++) begin
      a = NODE_W'($urandom_range(0, lim - 1));
      b = NODE_W'($urandom_range(0, lim - 1));
      if (comp_tag[a] != comp_tag[b]) return 1'b1;
    end
    for (t = 0; t < lim; t++)
      for (u = 0; u < lim; u++)
        if (comp_tag[t] != comp_tag[u]) begin
          a = NODE_W'(t);
          b = NODE_W'(u);
          return 1'b1;
        end
    return 1'b0;
  endfunction

  function automatic void plan_item(logic m, int a, int b);
    plan_row_t p;
    p = '{ROW_ITEM, 0, {m, NODE_W'(a), NODE_W'(b)}, 1'b0, '0};
    plan.push_back(p);
  endfunction

  function automatic void plan_known(logic m, int a, int b, gfc_out_t want);
    plan_row_t p;
    p = '{ROW_ITEM, 0, {m, NODE_W'(a), NODE_W'(b)}, 1'b1, want};
    plan.push_back(p);
  endfunction

  function automatic void plan_count(int v);
    plan_row_t p;
    p = '{ROW_WRITE, v, '0, 1'b0, '0};
    plan.push_back(p);
  endfunction

  // Sends one item; the expectation is queued at the accepting edge
  task automatic run_item(gfc_in_t it, bit known, gfc_out_t want);
    int       gap;
    gfc_out_t predicted;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predicted = apply_graph_item(it);
    awaited_results.push_back(known ? want : predicted);
  endtask

  // Register write once the unit is drained, followed by a readback
  task automatic write_vertex_count(int value);
    logic [31:0] seen;
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VERTEX_COUNT_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    vcount = value[VC_W-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (seen !== {{(32-VC_W){1'b0}}, vcount})
      note_mismatch("vertex_count readback", seen, vcount);
  endtask

  task automatic walk_plan(int from, int upto);
    int i;
    for (i = from; i < upto; i++) begin
      if (plan[i].kind == ROW_WRITE) write_vertex_count(plan[i].count);
      else run_item(plan[i].item, plan[i].known, plan[i].want);
    end
  endtask

  // Receiver stalls: random lengths, off during quiet stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_span();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    gfc_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result with nothing expected", out_data, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.forest !== want.forest)
          note_mismatch("forest", out_data.forest, want.forest);
        if (out_data.already_linked !== want.already_linked)
          note_mismatch("already_linked", out_data.already_linked, want.already_linked);
        if (out_data.row_bits !== want.row_bits)
          note_mismatch("row_bits", out_data.row_bits, want.row_bits);
        if (out_data.error !== want.error)
          note_mismatch("error", out_data.error, want.error);
      end
    end
  end

  initial begin
    int                cycle_part;
    int                lim;
    int                n;
    int                k;
    int                r;
    int                w;
    int                tree_counts[2] = '{12, 32};
    int                bulk_counts[9] = '{32, 1, 2, 0, 17, 63, 8, 32, 0};
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    gfc_in_t           it;

    clear_graph();

    // Acyclic directed rows: extremes, errors, count changes
    plan_known(MODE_READ, 0, 0, EMPTY_ROW);
    plan_known(MODE_READ, 31, 31, EMPTY_ROW);
    plan_known(MODE_ADD, 0, 31, {1'b1, 1'b0, 32'h8000_0000, 1'b0});
    plan_known(MODE_READ, 31, 0, {1'b1, 1'b0, 32'h0000_0001, 1'b0});
    plan_known(MODE_READ, 0, 17, {1'b1, 1'b0, 32'h8000_0000, 1'b0});
    plan_item(MODE_ADD, 30, 0);
    plan_count(1);
    plan_known(MODE_READ, 0, 31, {1'b1, 1'b0, 32'hC000_0000, 1'b0});
    plan_known(MODE_READ, 1, 0, BAD_VERTEX);
    plan_known(MODE_ADD, 0, 1, BAD_VERTEX);
    plan_known(MODE_ADD, 1, 0, BAD_VERTEX);
    plan_count(0);
    plan_known(MODE_READ, 0, 0, BAD_VERTEX);
    plan_known(MODE_ADD, 0, 0, BAD_VERTEX);
    plan_count(63);
    plan_item(MODE_READ, 31, 5);
    plan_item(MODE_ADD, 31, 15);
    plan_item(MODE_ADD, 16, 17);
    plan_item(MODE_READ, 15, 26);
    plan_count(5);
    plan_item(MODE_ADD, 4, 3);
    plan_item(MODE_ADD, 2, 4);
    plan_known(MODE_ADD, 3, 5, BAD_VERTEX);
    plan_known(MODE_READ, 31, 10, BAD_VERTEX);
    plan_item(MODE_READ, 4, 21);
    plan_item(MODE_ADD, 0, 3);
    plan_count(32);
    cycle_part = plan.size();
    // Cycle rows: closing a path, self-loop, repeated edge in both directions
    plan_item(MODE_ADD, 7, 20);
    plan_item(MODE_ADD, 9, 9);
    plan_item(MODE_ADD, 0, 31);
    plan_item(MODE_ADD, 31, 0);
    plan_item(MODE_READ, 9, 0);
    plan_count(3);
    plan_known(MODE_ADD, 31, 31, BAD_VERTEX_CY);
    plan_item(MODE_READ, 2, 31);
    plan_count(32);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    walk_plan(0, cycle_part);

    // The forest flag falls only once per reset, so trees are grown first
    // from edges that join separate components
    foreach (tree_counts[t]) begin
      write_vertex_count(tree_counts[t]);
      lim = vertex_limit();
      n = (lim < NV) ? 40 : 80;
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 9);
        if (r < 6 && pick_split_pair(lim, a, b)) begin
          it = {MODE_ADD, a, b};
        end else if (r < 8 || lim == NV) begin
          it = {MODE_READ, NODE_W'($urandom), NODE_W'($urandom)};
        end else begin
          it = {MODE_ADD, NODE_W'($urandom), NODE_W'($urandom_range(lim, NV - 1))};
          if ($urandom_range(0, 1) == 1) it = {MODE_ADD, it.node_b, it.node_a};
        end
        run_item(it, 1'b0, '0);
      end
    end

    walk_plan(cycle_part, plan.size());

    // Bulk traffic over several vertex counts, one stretch without idling
    bulk_counts[8] = $urandom_range(1, 32);
    foreach (bulk_counts[p]) begin
      write_vertex_count(bulk_counts[p]);
      no_gaps = (p == 4);
      lim = vertex_limit();
      n = (lim == 0) ? 30 : 115;
      for (k = 0; k < n; k++) begin
        it.mode = ($urandom_range(0, 2) == 0) ? MODE_READ : MODE_ADD;
        it.node_a = (lim > 0 && $urandom_range(0, 9) < 8) ?
                    NODE_W'($urandom_range(0, lim - 1)) : NODE_W'($urandom);
        it.node_b = (lim > 0 && $urandom_range(0, 9) < 8) ?
                    NODE_W'($urandom_range(0, lim - 1)) : NODE_W'($urandom);
        run_item(it, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    // Drain, then watch a little longer for stray results
    for (w = 0; w < 20000 && awaited_results.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0)
      note_mismatch("results never delivered", awaited_results.size(), 0);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/gfc_pkg.sv
src/gfc_cell.sv
src/graph_forest_checker_unit.sv
test/graph_forest_checker_unit_tb.sv
